### hw/rtl/pkis_pkg.sv
`default_nettype none
package pkis_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
  } pair_t;

  typedef struct packed {
    pair_t key;
    logic  last;
  } qitem_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // low word is kept negated while the high word is negative
  function automatic logic [31:0] adj_low(input logic [31:0] hi, input logic [31:0] lo);
    adj_low = hi[31] ? (32'd0 - lo) : lo;
  endfunction

  function automatic logic key_less(input pair_t a, input pair_t b);
    if (a.hi != b.hi) begin
      key_less = $signed(a.hi) < $signed(b.hi);
    end else begin
      key_less = $signed(a.lo) < $signed(b.lo);
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/pair_key_insertion_sorter_top.sv
`default_nettype none
// Insertion sorter for signed (high, low) pairs, ascending by high then by low
// (negated while high is negative), ties kept in arrival order. While a run is
// loading, one item is inserted per clock into a row of 64 compare-and-shift
// cells (a 2-entry queue sits between the input and the row). The item flagged
// last_item is inserted and then the row drains, one result per clock when
// out_ready allows; in_ready may drop once the queue fills during the drain.
// Items past 64 are discarded and every result of that run shows overflow.
module pair_key_insertion_sorter_top import pkis_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_high_word,
  input  wire logic [31:0] in_low_word,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_high,
  output logic [31:0]      out_low,
  output logic             out_last,
  output logic             out_overflow
);

  logic   q_valid;
  logic   q_ready;
  qitem_t q_item;

  pkis_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_high_word (in_high_word),
    .in_low_word  (in_low_word),
    .in_last_item (in_last_item),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  pkis_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_high     (out_high),
    .out_low      (out_low),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule
`default_nettype wire

### hw/rtl/pkis_front.sv
`default_nettype none
module pkis_front import pkis_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_high_word,
  input  wire logic [31:0] in_low_word,
  input  wire logic        in_last_item,
  output logic             q_valid,
  input  wire logic        q_ready,
  output qitem_t           q_item
);

  qitem_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push, pop;
  qitem_t             wr_item;

  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_item.key.hi = in_high_word;
    wr_item.key.lo = adj_low(in_high_word, in_low_word);
    wr_item.last   = in_last_item;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pkis_back.sv
`default_nettype none
module pkis_back import pkis_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire qitem_t      q_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_high,
  output logic [31:0]      out_low,
  output logic             out_last,
  output logic             out_overflow
);

  state_t            state_r, state_nxt;
  pair_t             cell_r [DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_high_r;
  logic [31:0]       out_low_r;
  logic              out_last_r;
  logic              out_ovf_r;
  logic [DEPTH-1:0]  lt;
  logic              load_go, emit_go, full, slot_free;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign slot_free = !out_valid_r || out_ready;

  // lt[i]: new item lands at or before cell i; cell count acts as the open slot
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign lt[i] = (CNT_W'(i) < count_r) ? key_less(q_item.key, cell_r[i])
                                         : (CNT_W'(i) == count_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (q_valid && q_item.last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && count_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    emit_go = 1'b0;
    case (state_r)
      ST_LOAD: q_ready = 1'b1;
      ST_EMIT: emit_go = slot_free;
      default: begin
        q_ready = 1'b0;
        emit_go = 1'b0;
      end
    endcase
  end

  assign load_go = q_valid && q_ready;

  always_comb begin
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_go) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      count_nxt     = count_r - 1'b1;
      if (count_r == CNT_W'(1)) begin
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // insert shifts the tail up by one; emit shifts the whole row down
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (load_go && !full) begin
        if (lt[i]) begin
          if (i == 0) begin
            cell_r[i] <= q_item.key;
          end else if (!lt[(i == 0) ? 0 : i-1]) begin
            cell_r[i] <= q_item.key;
          end else begin
            cell_r[i] <= cell_r[(i == 0) ? 0 : i-1];
          end
        end
      end else if (emit_go && i < DEPTH-1) begin
        cell_r[i] <= cell_r[(i < DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_high_r <= cell_r[0].hi;
      out_low_r  <= adj_low(cell_r[0].hi, cell_r[0].lo);
      out_last_r <= (count_r == CNT_W'(1));
      out_ovf_r  <= drop_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_high     = out_high_r;
  assign out_low      = out_low_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(drop_r) |-> $past(count_r) == CNT_W'(DEPTH))
    else $error("drop flag set with room in the store");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && count_r == '0) |-> !drop_r)
    else $error("drop flag survived an emptied run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && count_r == CNT_W'(1)) |=> (out_last && state_r == ST_LOAD && count_r == '0))
    else $error("run end not marked on final item");

endmodule
`default_nettype wire

### test/sorted_run_checker.sv
module sorted_run_checker import pkis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_high_word,
  input  logic [31:0] in_low_word,
  input  logic        in_last_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_high,
  input  logic [31:0] out_low,
  input  logic        out_last,
  input  logic        out_overflow,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] hi;
    logic [31:0] lo;
    logic        last;
    logic        ovf;
  } sorted_result_t;

  pair_t          held_keys [DEPTH];
  int             held_count = 0;
  logic           held_dropped = 1'b0;
  sorted_result_t owed_results [$];
  int             errs = 0;
  int             owed_count = 0;

  assign fail_count = errs;
  assign pending    = owed_count;

  // unsigned rank equal to signed (hi, lo) order
  function automatic logic [63:0] sort_rank(input pair_t p);
    return {~p.hi[31], p.hi[30:0], ~p.lo[31], p.lo[30:0]};
  endfunction

  function automatic logic [31:0] flip_low(input logic [31:0] hi, input logic [31:0] lo);
    return hi[31] ? -lo : lo;
  endfunction

  // insert one item; on the last item of a run, queue the whole sorted run
  task automatic insert_key(input logic [31:0] hi, input logic [31:0] lo, input logic last);
    pair_t          p;
    int             j;
    sorted_result_t r;
    p.hi = hi;
    p.lo = flip_low(hi, lo);
    if (held_count < DEPTH) begin
      j = held_count;
      // strict compare keeps equal keys in arrival order
      while (j > 0 && sort_rank(p) < sort_rank(held_keys[j-1])) begin
        held_keys[j] = held_keys[j-1];
        j--;
      end
      held_keys[j] = p;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < held_count; k++) begin
        r.hi   = held_keys[k].hi;
        r.lo   = flip_low(held_keys[k].hi, held_keys[k].lo);
        r.last = (k == held_count - 1);
        r.ovf  = held_dropped;
        owed_results.push_back(r);
      end
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    sorted_result_t want;
    if (!rst_n) begin
      held_count   = 0;
      held_dropped = 1'b0;
      owed_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t ns: result with none outstanding: high %h low %h last %b ovf %b",
                   $time, out_high, out_low, out_last, out_overflow);
          errs++;
        end else begin
          want = owed_results.pop_front();
          check_field("out_high", want.hi, out_high);
          check_field("out_low", want.lo, out_low);
          check_field("out_last", {31'd0, want.last}, {31'd0, out_last});
          check_field("out_overflow", {31'd0, want.ovf}, {31'd0, out_overflow});
        end
      end
      if (in_valid && in_ready) begin
        insert_key(in_high_word, in_low_word, in_last_item);
      end
    end
    owed_count <= owed_results.size();
  end

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 450;
  localparam int CALM_AFTER  = 390;
  localparam int LIMIT       = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_high_word = '0;
  logic [31:0] in_low_word = '0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_high;
  logic [31:0] out_low;
  logic        out_last;
  logic        out_overflow;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   items_sent = 0;
  logic calm = 1'b0;
  int   tx_odds = 0;
  int   rx_odds = 0;
  int   rx_stall_left = 0;

  always #6 clk = ~clk;

  pair_key_insertion_sorter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_high_word(in_high_word),
    .in_low_word (in_low_word),
    .in_last_item(in_last_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_high    (out_high),
    .out_low     (out_low),
    .out_last    (out_last),
    .out_overflow(out_overflow)
  );

  sorted_run_checker run_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_high_word(in_high_word),
    .in_low_word (in_low_word),
    .in_last_item(in_last_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_high    (out_high),
    .out_low     (out_low),
    .out_last    (out_last),
    .out_overflow(out_overflow),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("pair_key_insertion_sorter_top: mismatch");
    $finish;
  end

  // receiver: random stall bursts, odds re-picked now and then
  always @(posedge clk) begin
    if (cycle_count % 97 == 0) begin
      rx_odds <= $urandom_range(0, 3);
    end
    if (calm) begin
      out_ready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 11) < rx_odds) begin
      rx_stall_left <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // mostly corner values and small numbers so keys tie often
  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'h0000_0000;
      3: v = 32'hffff_ffff;
      4, 5: begin
        v = $urandom_range(0, 6);
        v = v - 32'd3;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_pair(input logic [31:0] hi, input logic [31:0] lo, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 9) < tx_odds) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_high_word <= hi;
    in_low_word  <= lo;
    in_last_item <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int run_idx;
    int run_len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner values, equal keys, most negative low with negative high
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h0000_0000, 1'b0);
    send_pair(32'h0000_0000, 32'h8000_0000, 1'b0);
    send_pair(32'hffff_ffff, 32'h0000_0001, 1'b0);
    send_pair(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_pair(32'h0000_0001, 32'hffff_ffff, 1'b1);
    // run of one item
    send_pair(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    // low word order flips under a negative high
    send_pair(32'hffff_fffe, 32'h0000_0005, 1'b0);
    send_pair(32'hffff_fffe, 32'hffff_fffb, 1'b0);
    send_pair(32'hffff_fffe, 32'h0000_0000, 1'b0);
    send_pair(32'h0000_0002, 32'h0000_0005, 1'b0);
    send_pair(32'h0000_0002, 32'hffff_fffb, 1'b0);
    send_pair(32'h0000_0002, 32'h0000_0000, 1'b1);
    drain_results();

    run_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      // one run fills the store and drops its last item, one fills it exactly
      if (run_idx == 1) begin
        run_len = 65;
      end else if (run_idx == 4) begin
        run_len = 64;
      end else if ($urandom_range(0, 19) == 0) begin
        run_len = $urandom_range(60, 70);
      end else begin
        run_len = $urandom_range(1, 12);
      end
      if (run_idx == 8) begin
        drain_results();
      end
      calm    = (items_sent >= CALM_AFTER);
      tx_odds = $urandom_range(0, 3);
      for (int i = 0; i < run_len; i++) begin
        send_pair(pick_word(), pick_word(), i == run_len - 1);
      end
      run_idx++;
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("pair_key_insertion_sorter_top: match");
    end else begin
      $display("pair_key_insertion_sorter_top: mismatch");
    end
    $finish;
  end

endmodule
